// ----- rtl/cwcs_pkg.sv -----
// shared constants for the closed walk cycle splitter
`timescale 1ns / 1ps
package cwcs_pkg;

	localparam int LABEL_W        = 4;
	localparam int NUM_LABELS_DEF = 12;

endpackage

// ----- rtl/cwcs_if.sv -----
// walk input and triple output channel interfaces
`timescale 1ns / 1ps
interface cwcs_in_if
	import cwcs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] label;
	logic               last;

	modport source (output valid, output label, output last, input ready);
	modport sink   (input valid, input label, input last, output ready);
endinterface

interface cwcs_out_if
	import cwcs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] from_label;
	logic [LABEL_W-1:0] mid_label;
	logic [LABEL_W-1:0] next_label;
	logic               cycle_end;
	logic               walk_end;

	modport source (output valid, output from_label, output mid_label, output next_label,
		output cycle_end, output walk_end, input ready);
	modport sink   (input valid, input from_label, input mid_label, input next_label,
		input cycle_end, input walk_end, output ready);
endinterface

// ----- rtl/closed_walk_cycle_splitter_unit.sv -----
// top level: splits a closed walk into simple cycles and emits (u,v,w) triples
// Labels arrive one per transaction on walk; a label not yet on the stack is
// pushed in the cycle it is accepted. A label already on the stack looks up
// its stack index, then streams the run of k members out of the label stack
// ram through its single read port, one read a cycle unless the output
// stalls, and delivers k triples at one a cycle while triple is ready. An
// item marked last is followed by a replay of the whole stack of depth d
// that yields the final cycle with walk_end on its last triple, after which
// the block is clear for the next walk. Out-of-range labels are dropped.
`timescale 1ns / 1ps
module closed_walk_cycle_splitter_unit
	import cwcs_pkg::*;
#(
	parameter int NUM_LABELS = NUM_LABELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cwcs_in_if.sink    walk,
	cwcs_out_if.source triple
);

	localparam int IDX_W   = $clog2(NUM_LABELS);
	localparam int DEPTH_W = $clog2(NUM_LABELS + 1);
	localparam int CNT_W   = $clog2(NUM_LABELS + 3);

	typedef enum logic [1:0] {S_IDLE, S_POS, S_RUN, S_FINISH} state_t;

	state_t                 state_q;
	logic [DEPTH_W-1:0]     depth_q;
	logic [NUM_LABELS-1:0]  present_q;
	logic                   started_q;
	logic [LABEL_W-1:0]     label_q;
	logic                   last_q;
	logic                   replay_q;
	logic [DEPTH_W-1:0]     from_q;
	logic [CNT_W-1:0]       len_q;
	logic [DEPTH_W-1:0]     rd_addr_q;
	logic [CNT_W-1:0]       issued_q;
	logic [CNT_W-1:0]       consumed_q;
	logic                   fresh_s1;
	logic [LABEL_W-1:0]     win0_q;
	logic [LABEL_W-1:0]     win1_q;
	logic                   out_valid_q;
	logic [LABEL_W-1:0]     from_label_q;
	logic [LABEL_W-1:0]     mid_label_q;
	logic [LABEL_W-1:0]     next_label_q;
	logic                   cycle_end_q;
	logic                   walk_end_q;

	logic                   walk_acc;
	logic                   lbl_ok;
	logic [IDX_W-1:0]       in_idx;
	logic [IDX_W-1:0]       lbl_idx;
	logic                   in_present;
	logic                   push_now;
	logic                   out_free;
	logic                   consume;
	logic                   emit;
	logic                   run_done;
	logic                   issue;
	logic                   stk_we;
	logic [IDX_W-1:0]       stk_waddr;
	logic [LABEL_W-1:0]     stk_wdata;
	logic [LABEL_W-1:0]     stk_rdata;
	logic [IDX_W-1:0]       pos_waddr;
	logic [IDX_W-1:0]       pos_wdata;
	logic [IDX_W-1:0]       pos_rdata;

	assign walk.ready   = (state_q == S_IDLE);
	assign walk_acc     = walk.valid && walk.ready;
	assign lbl_ok       = 32'(walk.label) < NUM_LABELS;
	assign in_idx       = IDX_W'(walk.label);
	assign lbl_idx      = IDX_W'(label_q);
	assign in_present   = lbl_ok && present_q[in_idx];
	assign push_now     = walk_acc && lbl_ok && !present_q[in_idx]
		&& (depth_q < DEPTH_W'(NUM_LABELS));

	assign out_free = !out_valid_q || triple.ready;
	// first two reads of a run only prime the window
	assign consume  = (state_q == S_RUN) && fresh_s1
		&& ((consumed_q < CNT_W'(2)) || out_free);
	assign emit     = consume && (consumed_q >= CNT_W'(2));
	assign run_done = consume && (consumed_q == len_q + CNT_W'(1));
	assign issue    = (state_q == S_RUN) && (issued_q != len_q + CNT_W'(2))
		&& (!fresh_s1 || consume);

	// the only writes are pushes: on acceptance, or the cut label after a run
	assign stk_we    = push_now || (run_done && !replay_q);
	assign stk_waddr = push_now ? IDX_W'(depth_q) : IDX_W'(from_q);
	assign stk_wdata = push_now ? walk.label : label_q;
	assign pos_waddr = push_now ? in_idx : lbl_idx;
	assign pos_wdata = push_now ? IDX_W'(depth_q) : IDX_W'(from_q);

	cwcs_ram #(
		.WIDTH (LABEL_W),
		.DEPTH (NUM_LABELS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (issue),
		.raddr (IDX_W'(rd_addr_q)),
		.rdata (stk_rdata)
	);

	cwcs_ram #(
		.WIDTH (IDX_W),
		.DEPTH (NUM_LABELS)
	) u_pos_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.re    (walk_acc && lbl_ok),
		.raddr (in_idx),
		.rdata (pos_rdata)
	);

	assign triple.valid      = out_valid_q;
	assign triple.from_label = from_label_q;
	assign triple.mid_label  = mid_label_q;
	assign triple.next_label = next_label_q;
	assign triple.cycle_end  = cycle_end_q;
	assign triple.walk_end   = walk_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			present_q   <= '0;
			started_q   <= 1'b0;
			replay_q    <= 1'b0;
			fresh_s1    <= 1'b0;
			issued_q    <= '0;
			consumed_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q  <= 1'b1;
				from_label_q <= win0_q;
				mid_label_q  <= win1_q;
				next_label_q <= stk_rdata;
				cycle_end_q  <= run_done;
				walk_end_q   <= run_done && replay_q;
			end else if (triple.ready) begin
				out_valid_q <= 1'b0;
			end

			if (issue) begin
				fresh_s1 <= 1'b1;
			end else if (consume) begin
				fresh_s1 <= 1'b0;
			end

			if (issue) begin
				issued_q <= issued_q + CNT_W'(1);
				// walk the run cyclically from its base
				if (rd_addr_q + DEPTH_W'(1) == depth_q) begin
					rd_addr_q <= from_q;
				end else begin
					rd_addr_q <= rd_addr_q + DEPTH_W'(1);
				end
			end

			if (consume) begin
				win0_q     <= win1_q;
				win1_q     <= stk_rdata;
				consumed_q <= consumed_q + CNT_W'(1);
				// members of the run leave the stack as they are read
				if (consumed_q < len_q) begin
					present_q[IDX_W'(stk_rdata)] <= 1'b0;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (walk_acc) begin
						label_q  <= walk.label;
						last_q   <= walk.last;
						replay_q <= 1'b0;
						if (lbl_ok) begin
							started_q <= 1'b1;
						end
						if (in_present) begin
							state_q <= S_POS;
						end else begin
							if (push_now) begin
								present_q[in_idx] <= 1'b1;
								depth_q           <= depth_q + DEPTH_W'(1);
							end
							state_q <= walk.last ? S_FINISH : S_IDLE;
						end
					end
				end
				S_POS: begin
					from_q     <= DEPTH_W'(pos_rdata);
					rd_addr_q  <= DEPTH_W'(pos_rdata);
					len_q      <= CNT_W'(depth_q - DEPTH_W'(pos_rdata));
					issued_q   <= '0;
					consumed_q <= '0;
					state_q    <= S_RUN;
				end
				S_FINISH: begin
					// the first label always sits at the stack base
					if (started_q && (depth_q != '0)) begin
						from_q     <= '0;
						rd_addr_q  <= '0;
						len_q      <= CNT_W'(depth_q);
						issued_q   <= '0;
						consumed_q <= '0;
						replay_q   <= 1'b1;
						state_q    <= S_RUN;
					end else begin
						depth_q   <= '0;
						present_q <= '0;
						started_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				S_RUN: begin
					if (run_done) begin
						if (replay_q) begin
							depth_q   <= '0;
							present_q <= '0;
							started_q <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							// cut vertex goes back on at the run base
							present_q[lbl_idx] <= 1'b1;
							depth_q            <= from_q + DEPTH_W'(1);
							state_q            <= last_q ? S_FINISH : S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/cwcs_ram.sv -----
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module cwcs_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 12,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
